// File: rtl/core/rmst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range min/max segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int WORD_W    = 64;
	localparam int POS_W     = 10;
	localparam int END_W     = 11;
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 128;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t MOST_POS = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_LEAF,
		ST_UPD_LEVEL,
		ST_QRY_WALK,
		ST_QRY_FIN
	} state_t;

	// Datapath controls driven by the sequencer.
	typedef struct packed {
		logic leaf;
		logic level;
		logic acc_init;
		logic acc_l;
		logic acc_r;
	} alu_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/rmst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rmst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic      [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule
`default_nettype wire

// File: rtl/core/rmst_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_alu
// Min/max datapath: parent recompute on update, left and right accumulators
// on query, and the final merge of the two query sides.
// ----------------------------------------------------------------------------
module rmst_alu (
	input  wire logic                clk,
	input  wire rmst_pkg::alu_ctrl_t ctrl,
	input  wire rmst_pkg::word_t     leaf_value,
	input  wire rmst_pkg::word_t     rd_min_a,
	input  wire rmst_pkg::word_t     rd_min_b,
	input  wire rmst_pkg::word_t     rd_max_a,
	input  wire rmst_pkg::word_t     rd_max_b,
	output rmst_pkg::word_t          wr_min,
	output rmst_pkg::word_t          wr_max,
	output rmst_pkg::word_t          res_min,
	output rmst_pkg::word_t          res_max
);
	import rmst_pkg::*;

	word_t cur_min_q, cur_max_q;
	word_t min_l_q, min_r_q, max_l_q, max_r_q;

	// On a level step, port A holds the sibling of the node last written.
	always_comb begin
		if (ctrl.leaf) begin
			wr_min = leaf_value;
			wr_max = leaf_value;
		end else begin
			wr_min = (rd_min_a < cur_min_q) ? rd_min_a : cur_min_q;
			wr_max = (rd_max_a > cur_max_q) ? rd_max_a : cur_max_q;
		end
	end

	assign res_min = (min_r_q < min_l_q) ? min_r_q : min_l_q;
	assign res_max = (max_r_q > max_l_q) ? max_r_q : max_l_q;

	always_ff @(posedge clk) begin
		if (ctrl.leaf || ctrl.level) begin
			cur_min_q <= wr_min;
			cur_max_q <= wr_max;
		end
		if (ctrl.acc_init) begin
			min_l_q <= MOST_POS;
			min_r_q <= MOST_POS;
			max_l_q <= MOST_NEG;
			max_r_q <= MOST_NEG;
		end else begin
			if (ctrl.acc_l) begin
				min_l_q <= (rd_min_a < min_l_q) ? rd_min_a : min_l_q;
				max_l_q <= (rd_max_a > max_l_q) ? rd_max_a : max_l_q;
			end
			if (ctrl.acc_r) begin
				min_r_q <= (rd_min_b < min_r_q) ? rd_min_b : min_r_q;
				max_r_q <= (rd_max_b > max_r_q) ? rd_max_b : max_r_q;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/range_min_max_segment_tree.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_min_max_segment_tree
// Bottom-up min and max segment trees over LEAVES signed 64-bit leaves.
// ----------------------------------------------------------------------------
// Input beats carry a command in s_tuser: an update writes one leaf and
// returns nothing, a query over [position, range_end) returns one output
// beat with the range minimum and maximum. An empty range returns the most
// positive value as minimum and the most negative value as maximum.
// Both trees sit in RAMs with registered read ports. An update does one
// leaf write, then one sibling read and parent write per level. A query
// does one pair of node reads per level, then a merge into the output
// register. One command is in work at a time. After reset the block
// sweeps both RAMs, one entry per cycle, over all 2*LEAVES entries with
// s_tready low. A stalled output beat holds in the output register;
// updates continue meanwhile, and the next query waits only at its final
// merge until the register is free.
// ----------------------------------------------------------------------------
module range_min_max_segment_tree #(
	parameter int LEAVES = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// position [9:0], range_end [20:10], value [84:21], zero [87:85]
	input  wire logic [rmst_pkg::S_TDATA_W-1:0]     s_tdata,
	// command [0]
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// range_min [63:0], range_max [127:64]
	output logic      [rmst_pkg::M_TDATA_W-1:0]     m_tdata
);
	import rmst_pkg::*;

	localparam int NW = $clog2(2 * LEAVES);
	localparam int IW = NW + 1;

	state_t state_q, state_d;

	logic [NW-1:0] clr_q, k_q;
	logic [IW-1:0] b_q, e_q;
	word_t         value_q;
	logic          flag_l_s1, flag_r_s1;
	logic          out_valid_q;
	word_t         out_min_q, out_max_q;

	logic [POS_W-1:0] in_pos;
	logic [END_W-1:0] in_end;
	word_t            in_value;
	logic             accept;
	logic [31:0]      pos32, end32, leaves32, eclamp32;
	logic             pos_ok, nonempty;
	logic             clr_last, upd_top, walk_go, fin_go;
	logic [NW-1:0]    parent;
	logic [IW-1:0]    e_m1;

	logic          we;
	logic [NW-1:0] waddr, raddr_a, raddr_b;
	word_t         wmin, wmax;
	word_t         rd_min_a, rd_min_b, rd_max_a, rd_max_b;
	word_t         alu_wr_min, alu_wr_max, res_min, res_max;
	alu_ctrl_t     ctrl;
	logic          issue, out_load;

	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_end   = s_tdata[POS_W+END_W-1:POS_W];
	assign in_value = s_tdata[POS_W+END_W+WORD_W-1:POS_W+END_W];
	assign accept   = s_tvalid && s_tready;

	assign pos32    = 32'(in_pos);
	assign end32    = 32'(in_end);
	assign leaves32 = 32'(LEAVES);
	assign eclamp32 = (end32 > leaves32) ? leaves32 : end32;
	assign pos_ok   = pos32 < leaves32;
	// The clamped end never exceeds LEAVES, so this also empties a
	// query that starts past the leaves.
	assign nonempty = pos32 < eclamp32;

	assign clr_last = clr_q == NW'(2 * LEAVES - 1);
	assign parent   = k_q >> 1;
	assign upd_top  = parent == NW'(1);
	assign walk_go  = b_q < e_q;
	assign e_m1     = e_q - IW'(1);
	assign fin_go   = !out_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == CMD_QUERY) state_d = ST_QRY_WALK;
					else if (pos_ok) state_d = ST_UPD_LEAF;
				end
			end
			ST_UPD_LEAF: begin
				state_d = ST_UPD_LEVEL;
			end
			ST_UPD_LEVEL: begin
				if (upd_top) state_d = ST_IDLE;
			end
			ST_QRY_WALK: begin
				if (!walk_go) state_d = ST_QRY_FIN;
			end
			ST_QRY_FIN: begin
				if (fin_go) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Outputs. During an update, the port A read never touches the entry
	// being written: it is always the sibling of that node.
	always_comb begin
		s_tready      = 1'b0;
		we            = 1'b0;
		waddr         = k_q;
		wmin          = alu_wr_min;
		wmax          = alu_wr_max;
		raddr_a       = {k_q[NW-1:1], ~k_q[0]};
		raddr_b       = e_m1[NW-1:0];
		ctrl          = '0;
		ctrl.acc_l    = flag_l_s1;
		ctrl.acc_r    = flag_r_s1;
		issue         = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wmin  = MOST_POS;
				wmax  = MOST_NEG;
			end
			ST_IDLE: begin
				s_tready      = 1'b1;
				ctrl.acc_init = 1'b1;
			end
			ST_UPD_LEAF: begin
				we        = 1'b1;
				waddr     = k_q;
				ctrl.leaf = 1'b1;
			end
			ST_UPD_LEVEL: begin
				we         = 1'b1;
				waddr      = parent;
				ctrl.level = 1'b1;
				raddr_a    = {parent[NW-1:1], ~parent[0]};
			end
			ST_QRY_WALK: begin
				raddr_a = b_q[NW-1:0];
				raddr_b = e_m1[NW-1:0];
				issue   = walk_go;
			end
			ST_QRY_FIN: begin
				out_load = fin_go;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			b_q         <= '0;
			e_q         <= '0;
			flag_l_s1   <= 1'b0;
			flag_r_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			flag_l_s1 <= issue && b_q[0];
			flag_r_s1 <= issue && e_q[0];
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NW'(1);
			end
			if (accept) begin
				k_q <= NW'(pos32 + leaves32);
				if (nonempty) begin
					b_q <= IW'(pos32 + leaves32);
					e_q <= IW'(eclamp32 + leaves32);
				end else begin
					b_q <= '0;
					e_q <= '0;
				end
			end else if (state_q == ST_UPD_LEVEL) begin
				k_q <= parent;
			end else if (issue) begin
				b_q <= (b_q + IW'(b_q[0])) >> 1;
				e_q <= e_q >> 1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= in_value;
		end
		if (out_load) begin
			out_min_q <= res_min;
			out_max_q <= res_max;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_max_q, out_min_q};

	rmst_ram #(
		.WIDTH (WORD_W),
		.DEPTH (2 * LEAVES)
	) u_min_ram (
		.clk       (clk),
		.wr_en     (we),
		.wr_addr   (waddr),
		.wr_data   (wmin),
		.rd_addr_a (raddr_a),
		.rd_data_a (rd_min_a),
		.rd_addr_b (raddr_b),
		.rd_data_b (rd_min_b)
	);

	rmst_ram #(
		.WIDTH (WORD_W),
		.DEPTH (2 * LEAVES)
	) u_max_ram (
		.clk       (clk),
		.wr_en     (we),
		.wr_addr   (waddr),
		.wr_data   (wmax),
		.rd_addr_a (raddr_a),
		.rd_data_a (rd_max_a),
		.rd_addr_b (raddr_b),
		.rd_data_b (rd_max_b)
	);

	rmst_alu u_alu (
		.clk        (clk),
		.ctrl       (ctrl),
		.leaf_value (value_q),
		.rd_min_a   (rd_min_a),
		.rd_min_b   (rd_min_b),
		.rd_max_a   (rd_max_a),
		.rd_max_b   (rd_max_b),
		.wr_min     (alu_wr_min),
		.wr_max     (alu_wr_max),
		.res_min    (res_min),
		.res_max    (res_max)
	);

endmodule
`default_nettype wire
